// File: hdl/bmh_pkg.sv
// Package for the binary min-heap: sizes, command and status codes,
// controller states and the input and result beat types.
// Depends on nothing; binary_min_heap imports it.
`timescale 1ns / 1ps
`default_nettype none

package bmh_pkg;

  localparam int CAPACITY = 1024;
  localparam int VALUE_W  = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHILD_W  = IDX_W + 2;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DOWN_LOAD,
    S_SIFT_UP,
    S_SIFT_DOWN,
    S_RESP
  } state_e;

  typedef struct packed {
    cmd_e               command;
    logic [VALUE_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [VALUE_W-1:0] min_value;
    logic [CNT_W-1:0]   count;
    logic               empty_res;
    status_e            status;
  } out_beat_t;

endpackage

`default_nettype wire

// File: hdl/bmh_ram.sv
// Generic simple dual-port RAM: one write port and two read ports,
// all synchronous, with registered read data. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module bmh_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_a_i,
  input  wire logic [ADDR_W-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]  rdata_a_o,
  output logic      [WIDTH-1:0]  rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

// File: hdl/binary_min_heap.sv
// Top level of the binary min-heap priority queue: command decode, sift
// controller, root mirror and result register around the heap RAM.
// Depends on bmh_pkg and bmh_ram.
//
//   Channel  | Handshake                | Beat
//   ---------+--------------------------+----------------------------------
//   input    | in_valid_i / in_ready_o  | in_data_i  (command, value)
//   result   | out_valid_o / out_ready_i| out_data_o (min, count, empty, status)
//
// One command is worked at a time. A query or a refused command goes straight
// from acceptance to the result load; inserts and most deletes first run the
// sift loop, which moves one heap level per cycle, limited by the registered
// read data of the heap RAM.
// Reset clears the element count and the control state; the RAM is not cleared.
// A new command is accepted while a finished result still waits in the result
// register; only the next result load waits for out_ready_i.
`timescale 1ns / 1ps
`default_nettype none

module binary_min_heap (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire bmh_pkg::in_beat_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output bmh_pkg::out_beat_t      out_data_o
);

  import bmh_pkg::*;

  // Controller state. The sift keeps the moving value in hold_q and only
  // writes it once its final slot is known; each step writes the displaced
  // parent or child into the current hole.
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   node_q, node_d;
  logic [VALUE_W-1:0] hold_q, hold_d;
  status_e            status_q, status_d;

  // Copy of heap entry zero, kept current on every write to that entry, so
  // the minimum is available without another RAM read.
  logic [VALUE_W-1:0] root_q;

  logic               out_valid_q;
  out_beat_t          out_q;
  logic               load_out;

  // RAM port signals.
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [IDX_W-1:0]   mem_raddr_a;
  logic [IDX_W-1:0]   mem_raddr_b;
  logic [VALUE_W-1:0] mem_rdata_a;
  logic [VALUE_W-1:0] mem_rdata_b;

  bmh_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_W),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wdata_i  (mem_wdata),
    .raddr_a_i(mem_raddr_a),
    .raddr_b_i(mem_raddr_b),
    .rdata_a_o(mem_rdata_a),
    .rdata_b_o(mem_rdata_b)
  );

  // Index arithmetic for the walk. Parent of n is (n - 1) / 2; the children
  // of n are 2n + 1 and 2n + 2, kept two bits wider so that the bound check
  // against the count sees indexes past the end of the heap.
  logic [IDX_W-1:0]   tail_parent;
  logic [IDX_W-1:0]   node_parent;
  logic [IDX_W-1:0]   node_grand;
  logic [CHILD_W-1:0] left_idx;
  logic [CHILD_W-1:0] right_idx;
  logic [CHILD_W-1:0] cnt_ext;
  logic               take_left;
  logic               take_right;
  logic [CHILD_W-1:0] next_idx;
  logic [VALUE_W-1:0] next_val;
  logic [CHILD_W-1:0] next_left;
  logic [CHILD_W-1:0] next_right;

  assign tail_parent = (cnt_q[IDX_W-1:0] - 1'b1) >> 1;
  assign node_parent = (node_q - 1'b1) >> 1;
  assign node_grand  = (node_parent - 1'b1) >> 1;
  assign left_idx    = {1'b0, node_q, 1'b1};
  assign right_idx   = left_idx + 1'b1;
  assign cnt_ext     = CHILD_W'(cnt_q);

  // A child only counts when it lies inside the heap and is strictly smaller
  // than the value being sifted. With both smaller, ties go to the left.
  assign take_left  = (left_idx < cnt_ext) && (mem_rdata_a < hold_q);
  assign take_right = (right_idx < cnt_ext) && (mem_rdata_b < hold_q);

  always_comb begin
    if (take_left && take_right) begin
      if (mem_rdata_a > mem_rdata_b) begin
        next_idx = right_idx;
        next_val = mem_rdata_b;
      end else begin
        next_idx = left_idx;
        next_val = mem_rdata_a;
      end
    end else if (take_left) begin
      next_idx = left_idx;
      next_val = mem_rdata_a;
    end else begin
      next_idx = right_idx;
      next_val = mem_rdata_b;
    end
  end

  assign next_left  = {next_idx[CHILD_W-2:0], 1'b1};
  assign next_right = next_left + 1'b1;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    node_d      = node_q;
    hold_d      = hold_q;
    status_d    = status_q;
    mem_we      = 1'b0;
    mem_waddr   = node_q;
    mem_wdata   = hold_q;
    mem_raddr_a = '0;
    mem_raddr_b = '0;
    load_out    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          status_d = ST_OK;
          hold_d   = in_data_i.value[VALUE_W-1:0];
          node_d   = '0;
          case (in_data_i.command)
            CMD_INSERT: begin
              if (cnt_q == CNT_W'(CAPACITY)) begin
                status_d = ST_FULL;
                state_d  = S_RESP;
              end else begin
                // The new element starts as a hole at the end of the heap.
                cnt_d       = cnt_q + 1'b1;
                node_d      = cnt_q[IDX_W-1:0];
                mem_raddr_a = tail_parent;
                state_d     = S_SIFT_UP;
              end
            end
            CMD_DELETE: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_RESP;
              end else begin
                // Fetch the last element; it moves to the root.
                cnt_d       = cnt_q - 1'b1;
                mem_raddr_a = cnt_d[IDX_W-1:0];
                state_d     = (cnt_q == CNT_W'(1)) ? S_RESP : S_DOWN_LOAD;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_DOWN_LOAD: begin
        hold_d      = mem_rdata_a;
        mem_raddr_a = IDX_W'(1);
        mem_raddr_b = IDX_W'(2);
        state_d     = S_SIFT_DOWN;
      end

      S_SIFT_UP: begin
        mem_we = 1'b1;
        if ((node_q == '0) || (mem_rdata_a <= hold_q)) begin
          state_d = S_RESP;
        end else begin
          // Parent moves down into the hole; the hole moves up.
          mem_wdata   = mem_rdata_a;
          node_d      = node_parent;
          mem_raddr_a = node_grand;
        end
      end

      S_SIFT_DOWN: begin
        mem_we = 1'b1;
        if (!take_left && !take_right) begin
          state_d = S_RESP;
        end else begin
          // Smaller child moves up into the hole; the hole moves down.
          mem_wdata   = next_val;
          node_d      = next_idx[IDX_W-1:0];
          mem_raddr_a = next_left[IDX_W-1:0];
          mem_raddr_b = next_right[IDX_W-1:0];
        end
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q   <= node_d;
    hold_q   <= hold_d;
    status_q <= status_d;
    if (mem_we && (mem_waddr == '0)) begin
      root_q <= mem_wdata;
    end
  end

  // Result register. An empty heap reports a minimum of zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.min_value <= (cnt_q == '0) ? '0 : root_q;
      out_q.count     <= cnt_q;
      out_q.empty_res <= (cnt_q == '0);
      out_q.status    <= status_q;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // The element count never passes the capacity.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("heap count exceeds capacity");

  // The heap RAM is written only while a sift is in progress.
  a_write_in_sift : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == S_SIFT_UP) || (state_q == S_SIFT_DOWN)))
    else $error("heap RAM written outside a sift");

  // A refused insert is reported only with a full heap.
  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status == ST_FULL)) |-> (out_q.count == CNT_W'(CAPACITY)))
    else $error("full status reported with room left");

  // Loading the result register always presents a result next cycle.
  a_result_shown : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (out_valid_q && (state_q == S_IDLE)))
    else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire
